>>> rtl/core/isse_pkg.sv
// shared types and constants of the interval set subtract engine
// no dependencies
package isse_pkg;

  localparam int MAX_INTERVALS = 64;
  localparam int SITE_BITS     = 21;
  localparam int IDX_W         = $clog2(MAX_INTERVALS);
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
  localparam int SAMPLE_W      = 16;
  localparam int QUERY_W       = 20;
  localparam int CFG_IDX_W     = 2;

  localparam logic [SITE_BITS-1:0] RESET_SITES  = SITE_BITS'(1048576);
  localparam logic [SAMPLE_W-1:0]  RESET_SAMPLE = SAMPLE_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_SITE_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SIZE = CFG_IDX_W'(1);

  localparam logic [1:0] FUNC_INIT     = 2'd0;
  localparam logic [1:0] FUNC_REMOVE   = 2'd1;
  localparam logic [1:0] FUNC_ANCESTRY = 2'd2;
  localparam logic [1:0] FUNC_QUERY    = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_READ,
    OP_SUB,
    OP_SPLIT,
    OP_SUB_END,
    OP_MRG_FIRST,
    OP_MRG,
    OP_MRG_END,
    OP_QUERY,
    OP_DONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0]       func;
    logic             sub_go;
    logic [CNT_W-1:0] count;
    logic             split;
  } dp_status_t;

endpackage

>>> rtl/core/isse_ctrl.sv
// controller state machine: sequences the table scans of one request
// depends on isse_pkg
module isse_ctrl import isse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SUB_RD, S_SUB_EV, S_SUB_SPL, S_SUB_END,
    S_MRG_RD0, S_MRG_EV0, S_MRG_RD, S_MRG_EV, S_MRG_END,
    S_Q_RD, S_Q_EV, S_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] i_q;
  logic             last;

  assign last = (i_q + CNT_W'(1)) == status_i.count;
  assign busy_o = state_q != S_IDLE;

  always_comb begin
    cmd_o.idx = i_q[IDX_W-1:0];
    unique case (state_q)
      S_IDLE:     cmd_o.op = start_i ? OP_LOAD : OP_NONE;
      S_DISPATCH: cmd_o.op = (status_i.func == FUNC_INIT) ? OP_INIT : OP_NONE;
      S_SUB_RD, S_MRG_RD0, S_MRG_RD, S_Q_RD: cmd_o.op = OP_READ;
      S_SUB_EV:   cmd_o.op = OP_SUB;
      S_SUB_SPL:  cmd_o.op = OP_SPLIT;
      S_SUB_END:  cmd_o.op = OP_SUB_END;
      S_MRG_EV0:  cmd_o.op = OP_MRG_FIRST;
      S_MRG_EV:   cmd_o.op = OP_MRG;
      S_MRG_END:  cmd_o.op = OP_MRG_END;
      S_Q_EV:     cmd_o.op = OP_QUERY;
      S_DONE:     cmd_o.op = OP_DONE;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  // state and scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          i_q <= '0;
          // init always leaves one interval to scan
          priority if (status_i.func == FUNC_INIT)
            state_q <= S_Q_RD;
          else if (status_i.func == FUNC_QUERY)
            state_q <= (status_i.count == '0) ? S_DONE : S_Q_RD;
          else if (status_i.sub_go)
            state_q <= (status_i.count == '0) ? S_SUB_END : S_SUB_RD;
          else if (status_i.func == FUNC_ANCESTRY)
            state_q <= (status_i.count == '0) ? S_DONE : S_MRG_RD0;
          else
            state_q <= (status_i.count == '0) ? S_DONE : S_Q_RD;
        end
        S_SUB_RD: state_q <= S_SUB_EV;
        S_SUB_EV: begin
          priority if (status_i.split) state_q <= S_SUB_SPL;
          else if (last) state_q <= S_SUB_END;
          else begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= S_SUB_RD;
          end
        end
        S_SUB_SPL: begin
          if (last) state_q <= S_SUB_END;
          else begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= S_SUB_RD;
          end
        end
        S_SUB_END: begin
          // count is updated here, the next pass checks it in the cycle after
          i_q     <= '0;
          state_q <= (status_i.func == FUNC_ANCESTRY) ? S_MRG_RD0 : S_Q_RD;
        end
        S_MRG_RD0: begin
          if (status_i.count == '0) state_q <= S_DONE;
          else state_q <= S_MRG_EV0;
        end
        S_MRG_EV0: begin
          if (last) state_q <= S_MRG_END;
          else begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= S_MRG_RD;
          end
        end
        S_MRG_RD: state_q <= S_MRG_EV;
        S_MRG_EV: begin
          if (last) state_q <= S_MRG_END;
          else begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= S_MRG_RD;
          end
        end
        S_MRG_END: begin
          i_q     <= '0;
          state_q <= S_Q_RD;
        end
        S_Q_RD: begin
          if (status_i.count == '0) state_q <= S_DONE;
          else state_q <= S_Q_EV;
        end
        S_Q_EV: begin
          if (last) state_q <= S_DONE;
          else begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= S_Q_RD;
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/isse_datapath.sv
// datapath: config registers, ping-pong interval table, total and result registers
// depends on isse_pkg
module isse_datapath import isse_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [SITE_BITS-1:0]   cfg_wdata_i,
  input  logic [1:0]             func_i,
  input  logic [SITE_BITS-1:0]   range_start_i,
  input  logic [SITE_BITS-1:0]   range_end_i,
  input  logic [SAMPLE_W-1:0]    ancestry_count_i,
  input  logic [QUERY_W-1:0]     query_site_i,
  input  dp_cmd_t                cmd_i,
  output dp_status_t             status_o,
  output logic                   done_o,
  output logic                   site_active_o,
  output logic [SITE_BITS-1:0]   active_total_o,
  output logic [CNT_W-1:0]       intervals_in_use_o,
  output logic                   table_full_o
);

  // two banks of packed {begin, finish}
  logic [2*SITE_BITS-1:0] mem_q [2*MAX_INTERVALS];
  logic [2*SITE_BITS-1:0] rd_data_q;
  logic                   rd_virt_q;

  logic [SITE_BITS-1:0] site_count_q, base_f_q;
  logic [SAMPLE_W-1:0]  sample_size_q;
  logic [1:0]           func_q;
  logic [SITE_BITS-1:0] lo_q, hi_q;
  logic [SAMPLE_W-1:0]  cnt_q;
  logic [QUERY_W-1:0]   site_q;

  logic                 bank_q, virt_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [SITE_BITS-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]     w_q, w_d;
  logic [SITE_BITS-1:0] cur_b_q, cur_b_d, cur_f_q, cur_f_d, split_f_q, split_f_d;
  logic                 hit_q, hit_d, refused_q, refused_d;
  logic                 bank_d, virt_d;

  logic                 wr_en;
  logic [SITE_BITS-1:0] wr_b, wr_f;
  logic [SITE_BITS-1:0] eb, ef;
  logic                 strict, split_ok;

  // entry read back, with the reset or init interval standing in for entry 0
  assign eb = rd_virt_q ? '0       : rd_data_q[2*SITE_BITS-1:SITE_BITS];
  assign ef = rd_virt_q ? base_f_q : rd_data_q[SITE_BITS-1:0];

  assign strict   = (lo_q > eb) && (hi_q < ef);
  assign split_ok = strict && (count_q < CNT_W'(MAX_INTERVALS));

  assign status_o.func   = func_q;
  assign status_o.sub_go = (lo_q < hi_q) &&
                           ((func_q == FUNC_REMOVE) ||
                            (func_q == FUNC_ANCESTRY && cnt_q == sample_size_q));
  assign status_o.count  = count_q;
  assign status_o.split  = (cmd_i.op == OP_SUB) && split_ok;

  // per-command next state
  always_comb begin
    count_d = count_q;  sum_d = sum_q;  w_d = w_q;
    cur_b_d = cur_b_q;  cur_f_d = cur_f_q;  split_f_d = split_f_q;
    hit_d = hit_q;  refused_d = refused_q;  bank_d = bank_q;  virt_d = virt_q;
    wr_en = 1'b0;  wr_b = eb;  wr_f = ef;
    unique case (cmd_i.op)
      OP_LOAD: begin
        w_d = '0;  hit_d = 1'b0;  refused_d = 1'b0;
      end
      OP_INIT: begin
        virt_d = 1'b1;  count_d = CNT_W'(1);  sum_d = site_count_q;
      end
      OP_SUB: begin
        priority if (hi_q <= eb || lo_q >= ef) begin
          wr_en = 1'b1;
        end else if (lo_q <= eb && hi_q >= ef) begin
          sum_d = sum_q - (ef - eb);
        end else if (strict) begin
          wr_en = 1'b1;
          if (split_ok) begin
            wr_f      = lo_q;
            split_f_d = ef;
          end else begin
            refused_d = 1'b1;
          end
        end else if (lo_q <= eb) begin
          sum_d = sum_q - (hi_q - eb);
          wr_en = 1'b1;  wr_b = hi_q;
        end else begin
          sum_d = sum_q - (ef - lo_q);
          wr_en = 1'b1;  wr_f = lo_q;
        end
        if (wr_en) w_d = w_q + CNT_W'(1);
      end
      OP_SPLIT: begin
        wr_en = 1'b1;  wr_b = hi_q;  wr_f = split_f_q;
        w_d   = w_q + CNT_W'(1);
        sum_d = sum_q - (hi_q - lo_q);
      end
      OP_SUB_END: begin
        count_d = w_q;  bank_d = ~bank_q;  virt_d = 1'b0;  w_d = '0;
      end
      OP_MRG_FIRST: begin
        cur_b_d = eb;  cur_f_d = ef;  w_d = '0;
      end
      OP_MRG: begin
        if (cur_f_q == eb) begin
          cur_f_d = ef;
        end else begin
          wr_en = 1'b1;  wr_b = cur_b_q;  wr_f = cur_f_q;
          w_d = w_q + CNT_W'(1);
          cur_b_d = eb;  cur_f_d = ef;
        end
      end
      OP_MRG_END: begin
        wr_en = 1'b1;  wr_b = cur_b_q;  wr_f = cur_f_q;
        count_d = w_q + CNT_W'(1);  bank_d = ~bank_q;  virt_d = 1'b0;
      end
      OP_QUERY: begin
        if ({1'b0, site_q} >= eb && {1'b0, site_q} < ef) hit_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // table memory: read the current bank, write the other one
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_READ) rd_data_q <= mem_q[{bank_q, cmd_i.idx}];
    if (wr_en) mem_q[{~bank_q, w_q[IDX_W-1:0]}] <= {wr_b, wr_f};
  end

  // captured request and scan scratch
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      func_q <= func_i;  lo_q <= range_start_i;  hi_q <= range_end_i;
      cnt_q  <= ancestry_count_i;  site_q <= query_site_i;
    end
    w_q <= w_d;  cur_b_q <= cur_b_d;  cur_f_q <= cur_f_d;  split_f_q <= split_f_d;
    hit_q <= hit_d;  refused_q <= refused_d;
    if (cmd_i.op == OP_DONE) begin
      site_active_o      <= hit_q;
      active_total_o     <= sum_q;
      intervals_in_use_o <= count_q;
      table_full_o       <= refused_q;
    end
  end

  // control state and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_count_q  <= RESET_SITES;
      sample_size_q <= RESET_SAMPLE;
      count_q       <= CNT_W'(1);
      sum_q         <= RESET_SITES;
      bank_q        <= 1'b0;
      virt_q        <= 1'b1;
      rd_virt_q     <= 1'b0;
      done_o        <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_SITE_COUNT) site_count_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == REG_SAMPLE_SIZE)
        sample_size_q <= cfg_wdata_i[SAMPLE_W-1:0];
      count_q <= count_d;
      sum_q   <= sum_d;
      bank_q  <= bank_d;
      virt_q  <= virt_d;
      if (cmd_i.op == OP_READ) rd_virt_q <= virt_q && (cmd_i.idx == '0);
      done_o  <= cmd_i.op == OP_DONE;
    end
  end

  // base finish of the virtual entry, set at reset and on init
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_f_q <= RESET_SITES;
    end else if (cmd_i.op == OP_INIT) begin
      base_f_q <= site_count_q;
    end
  end

endmodule

>>> rtl/core/interval_set_subtract_engine.sv
// top level of the interval set subtract engine
// depends on isse_pkg, isse_ctrl, isse_datapath
//
// usage: a request is taken at a clock edge with start_i high and busy_o low;
// func_i and the range, count and site fields are sampled then. busy_o stays
// high until the request is finished. one result comes back with done_o high
// for exactly one cycle; the receiver cannot stall and must take it then.
// config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 site_count,
// 1 sample_size); write only while busy_o is low and no result is pending.
// sequence: a dispatch state, then per table pass a read and an evaluate
// step per entry (up to 64) on the single table read port and a closing
// step; the membership pass has no closing step and a split adds a write
// step. remove does a subtract pass if range_start < range_end, ancestry
// a merge pass, after a subtract pass if also ancestry_count = sample_size;
// every request then does a membership pass unless the table is empty. a
// done state ends the request and done_o rises in the cycle after it.
// reset: the table holds one interval [0, 1048576), the total is 1048576,
// and config registers take their reset values; no clearing pass is needed.
module interval_set_subtract_engine import isse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           func_i,
  input  logic [SITE_BITS-1:0] range_start_i,
  input  logic [SITE_BITS-1:0] range_end_i,
  input  logic [SAMPLE_W-1:0]  ancestry_count_i,
  input  logic [QUERY_W-1:0]   query_site_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SITE_BITS-1:0] cfg_wdata_i,
  output logic                 done_o,
  output logic                 site_active_o,
  output logic [SITE_BITS-1:0] active_total_o,
  output logic [CNT_W-1:0]     intervals_in_use_o,
  output logic                 table_full_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  isse_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // table and arithmetic
  isse_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .func_i             (func_i),
    .range_start_i      (range_start_i),
    .range_end_i        (range_end_i),
    .ancestry_count_i   (ancestry_count_i),
    .query_site_i       (query_site_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .done_o             (done_o),
    .site_active_o      (site_active_o),
    .active_total_o     (active_total_o),
    .intervals_in_use_o (intervals_in_use_o),
    .table_full_o       (table_full_o)
  );

`ifndef SYNTH
  // a taken request keeps the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("request not taken");

  // a result comes out only once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");

  // the table never holds more than its depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> intervals_in_use_o <= CNT_W'(MAX_INTERVALS))
    else $error("interval count overflow");
`endif

endmodule
